@@ rtl/pkt_pkg.sv @@
package pkt_pkg;

	localparam int MAX_CLIENTS = 128;
	localparam int IDX_W       = $clog2(MAX_CLIENTS);
	localparam int CNT_W       = $clog2(MAX_CLIENTS + 1);
	localparam int CFG_IDX_W   = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ADDR   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_FIRST   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_SECOND  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_THIRD   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_FIRST  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_SECOND = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_THIRD  = 3'd6;

	localparam logic [15:0] OPEN_FIRST_RST   = 16'd1000;
	localparam logic [15:0] OPEN_SECOND_RST  = 16'd2000;
	localparam logic [15:0] OPEN_THIRD_RST   = 16'd3000;
	localparam logic [15:0] CLOSE_FIRST_RST  = 16'd4000;
	localparam logic [15:0] CLOSE_SECOND_RST = 16'd5000;
	localparam logic [15:0] CLOSE_THIRD_RST  = 16'd6000;

	// Actions.
	localparam logic [1:0] ACT_NONE   = 2'd0;
	localparam logic [1:0] ACT_GRANT  = 2'd1;
	localparam logic [1:0] ACT_REVOKE = 2'd2;

	// Events.
	localparam logic [3:0] EV_OTHER_HOST  = 4'd0;
	localparam logic [3:0] EV_UNKNOWN     = 4'd1;
	localparam logic [3:0] EV_TABLE_FULL  = 4'd2;
	localparam logic [3:0] EV_ADD_OPEN    = 4'd3;
	localparam logic [3:0] EV_ADD_CLOSE   = 4'd4;
	localparam logic [3:0] EV_ALREADY_OPEN  = 4'd5;
	localparam logic [3:0] EV_ALREADY_CLOSED = 4'd6;
	localparam logic [3:0] EV_OPEN_STEP   = 4'd7;
	localparam logic [3:0] EV_CLOSE_STEP  = 4'd8;
	localparam logic [3:0] EV_OPENED      = 4'd9;
	localparam logic [3:0] EV_CLOSED      = 4'd10;
	localparam logic [3:0] EV_WRONG_RESET = 4'd11;
	localparam logic [3:0] EV_NO_CHANGE   = 4'd12;

	typedef struct packed {
		logic [31:0] source_addr;
		logic [31:0] dest_addr;
		logic [15:0] dest_port;
	} pkt_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [3:0]  event_res;
		logic [6:0]  client_slot;
		logic [31:0] client_addr;
		logic        access_open;
	} res_t;

	typedef struct packed {
		logic [31:0] local_addr;
		logic [15:0] open_first;
		logic [15:0] open_second;
		logic [15:0] open_third;
		logic [15:0] close_first;
		logic [15:0] close_second;
		logic [15:0] close_third;
	} cfg_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [1:0]  open_prog;
		logic [1:0]  close_prog;
		logic        status;
	} ent_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		ent_t             wr_data;
	} tbl_req_t;

endpackage

@@ rtl/port_knock_tracker.sv @@
// Flow: an accepted packet passes through the states SEARCH and DECIDE, and then its result
// word is registered; the search ends early when the client is found, and other hosts skip it.
// A new packet is taken only in IDLE; the client table is searched one entry per cycle
// through its single read port. A waiting result does not block the next packet's search.
// Reset: configuration returns to its defaults and the client count to zero; the table
// contents are not cleared, since only entries below the count are ever read.
module port_knock_tracker import pkt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pkt_valid,
	output logic                 pkt_stall,
	input  pkt_t                 pkt,
	output logic                 res_valid,
	input  logic                 res_stall,
	output res_t                 res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	cfg_t     cfg_q;
	tbl_req_t req;
	ent_t     rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_addr   <= '0;
			cfg_q.open_first   <= OPEN_FIRST_RST;
			cfg_q.open_second  <= OPEN_SECOND_RST;
			cfg_q.open_third   <= OPEN_THIRD_RST;
			cfg_q.close_first  <= CLOSE_FIRST_RST;
			cfg_q.close_second <= CLOSE_SECOND_RST;
			cfg_q.close_third  <= CLOSE_THIRD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LOCAL_ADDR:   cfg_q.local_addr   <= cfg_data;
				REG_OPEN_FIRST:   cfg_q.open_first   <= cfg_data[15:0];
				REG_OPEN_SECOND:  cfg_q.open_second  <= cfg_data[15:0];
				REG_OPEN_THIRD:   cfg_q.open_third   <= cfg_data[15:0];
				REG_CLOSE_FIRST:  cfg_q.close_first  <= cfg_data[15:0];
				REG_CLOSE_SECOND: cfg_q.close_second <= cfg_data[15:0];
				REG_CLOSE_THIRD:  cfg_q.close_third  <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	pkt_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.pkt       (pkt),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.req       (req),
		.rdata     (rdata)
	);

	pkt_table u_table (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

endmodule

@@ rtl/pkt_table.sv @@
module pkt_table import pkt_pkg::*; (
	input  logic     clk,
	input  tbl_req_t req,
	output ent_t     rdata
);

	ent_t mem [MAX_CLIENTS];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rdata <= mem[req.rd_addr];
		end
	end

endmodule

@@ rtl/pkt_fsm.sv @@
module pkt_fsm import pkt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     pkt_valid,
	output logic     pkt_stall,
	input  pkt_t     pkt,
	output logic     res_valid,
	input  logic     res_stall,
	output res_t     res,
	output tbl_req_t req,
	input  ent_t     rdata
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;

	logic [1:0]       state_q;
	pkt_t             pkt_q;
	logic [CNT_W-1:0] idx_q;
	logic             chk_q;
	logic             found_q;
	logic [IDX_W-1:0] slot_q;
	ent_t             ent_q;
	logic [CNT_W-1:0] count_q;
	logic             res_valid_q;
	res_t             res_q;

	logic is_local, hit, more, out_free, accept, go;
	logic o1, o2, o3, c1, c2, c3;
	res_t res_d;
	ent_t ent_d;
	logic wr_d, add_d;
	logic [IDX_W-1:0] wr_slot;

	assign accept   = pkt_valid && !pkt_stall;
	assign is_local = (pkt_q.dest_addr == cfg.local_addr);
	assign hit      = chk_q && (rdata.addr == pkt_q.source_addr);
	assign more     = (idx_q < count_q);
	assign out_free = !res_valid_q || !res_stall;
	assign go       = (state_q == ST_DECIDE) && out_free;

	assign o1 = (pkt_q.dest_port == cfg.open_first);
	assign o2 = (pkt_q.dest_port == cfg.open_second);
	assign o3 = (pkt_q.dest_port == cfg.open_third);
	assign c1 = (pkt_q.dest_port == cfg.close_first);
	assign c2 = (pkt_q.dest_port == cfg.close_second);
	assign c3 = (pkt_q.dest_port == cfg.close_third);

	assign pkt_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// One entry is read per cycle; its compare happens the cycle after.
	always_comb begin
		req.rd_en   = (state_q == ST_SEARCH) && is_local && !hit && more;
		req.rd_addr = idx_q[IDX_W-1:0];
		req.wr_en   = go && wr_d;
		req.wr_addr = wr_slot;
		req.wr_data = ent_d;
	end

	always_comb begin
		res_d             = '0;
		res_d.action      = ACT_NONE;
		res_d.client_addr = pkt_q.source_addr;
		ent_d             = ent_q;
		wr_d              = 1'b0;
		add_d             = 1'b0;
		wr_slot           = slot_q;
		if (!is_local) begin
			res_d.event_res = EV_OTHER_HOST;
		end else if (!found_q) begin
			if (!o1 && !c1) begin
				res_d.event_res = EV_UNKNOWN;
			end else if (count_q >= CNT_W'(MAX_CLIENTS)) begin
				res_d.event_res = EV_TABLE_FULL;
			end else begin
				wr_d             = 1'b1;
				add_d            = 1'b1;
				wr_slot          = count_q[IDX_W-1:0];
				ent_d.addr       = pkt_q.source_addr;
				ent_d.status     = 1'b0;
				ent_d.open_prog  = o1 ? 2'd1 : 2'd0;
				ent_d.close_prog = o1 ? 2'd0 : 2'd1;
				res_d.event_res  = o1 ? EV_ADD_OPEN : EV_ADD_CLOSE;
				res_d.client_slot = 7'(count_q[IDX_W-1:0]);
			end
		end else begin
			wr_d              = 1'b1;
			res_d.client_slot = 7'(slot_q);
			res_d.access_open = ent_q.status;
			res_d.event_res   = EV_NO_CHANGE;
			if (o1 || o2 || o3) begin
				priority if (ent_q.status) begin
					res_d.event_res = EV_ALREADY_OPEN;
				end else if (o1) begin
					ent_d.open_prog = 2'd1;
					res_d.event_res = EV_OPEN_STEP;
				end else if (ent_q.open_prog == 2'd1 && o2) begin
					ent_d.open_prog = 2'd2;
					res_d.event_res = EV_OPEN_STEP;
				end else if (ent_q.open_prog == 2'd2 && o3) begin
					ent_d.status      = 1'b1;
					ent_d.open_prog   = 2'd0;
					res_d.action      = ACT_GRANT;
					res_d.event_res   = EV_OPENED;
					res_d.access_open = 1'b1;
				end else begin
					res_d.event_res = EV_NO_CHANGE;
				end
			end else if (c1 || c2 || c3) begin
				priority if (!ent_q.status) begin
					res_d.event_res = EV_ALREADY_CLOSED;
				end else if (c1) begin
					ent_d.close_prog = 2'd1;
					res_d.event_res  = EV_CLOSE_STEP;
				end else if (ent_q.close_prog == 2'd1 && c2) begin
					ent_d.close_prog = 2'd2;
					res_d.event_res  = EV_CLOSE_STEP;
				end else if (ent_q.close_prog == 2'd2 && c3) begin
					ent_d.status      = 1'b0;
					ent_d.close_prog  = 2'd0;
					res_d.action      = ACT_REVOKE;
					res_d.event_res   = EV_CLOSED;
					res_d.access_open = 1'b0;
				end else begin
					res_d.event_res = EV_NO_CHANGE;
				end
			end else begin
				ent_d.open_prog  = 2'd0;
				ent_d.close_prog = 2'd0;
				res_d.event_res  = EV_WRONG_RESET;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			chk_q       <= 1'b0;
			found_q     <= 1'b0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall && !go) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						chk_q   <= 1'b0;
						found_q <= 1'b0;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (!is_local) begin
						state_q <= ST_DECIDE;
					end else if (hit) begin
						found_q <= 1'b1;
						state_q <= ST_DECIDE;
					end else if (more) begin
						idx_q <= idx_q + 1'b1;
						chk_q <= 1'b1;
					end else begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						if (add_d) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pkt_q <= pkt;
		end
		if (state_q == ST_SEARCH && hit) begin
			ent_q  <= rdata;
			slot_q <= IDX_W'(idx_q - 1'b1);
		end
		if (go) begin
			res_q <= res_d;
		end
	end

endmodule

@@ bench/testbench.sv @@
module testbench import pkt_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 4000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	localparam logic [31:0] HOST_A = 32'h0A00_0001;
	localparam logic [31:0] HOST_B = 32'hFFFF_FFFF;
	localparam logic [31:0] HOST_C = 32'h0000_0000;

	typedef struct {
		pkt_t p;
		bit   typed;
		res_t want;
	} knock_row_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 pkt_valid = 1'b0;
	logic                 pkt_stall;
	pkt_t                 pkt = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	res_t                 res;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;

	// Tracker mirror: registers, client table and fill count.
	cfg_t        knock_cfg = '{32'h0, OPEN_FIRST_RST, OPEN_SECOND_RST, OPEN_THIRD_RST,
		CLOSE_FIRST_RST, CLOSE_SECOND_RST, CLOSE_THIRD_RST};
	logic [31:0] tab_addr   [MAX_CLIENTS];
	logic [1:0]  tab_open   [MAX_CLIENTS];
	logic [1:0]  tab_close  [MAX_CLIENTS];
	logic        tab_status [MAX_CLIENTS];
	int          known_count = 0;

	res_t        pending [$];
	logic [31:0] client_pool [$] = '{HOST_A, HOST_B, HOST_C};
	bit          calm = 1'b0;
	int          mismatches = 0;
	int          total_pkts = 0;
	int          host_pkts = 0;
	int          settings_done = 0;
	int          seen_event [16];
	int          quiet_cycles = 0;

	// Default registers throughout; rows without a typed result are predicted.
	knock_row_t script [23] = '{
		'{'{HOST_A, 32'h1, OPEN_FIRST_RST}, 1'b1,
			'{ACT_NONE, EV_OTHER_HOST, 7'd0, HOST_A, 1'b0}},
		'{'{HOST_A, 32'h0, 16'd7}, 1'b1,
			'{ACT_NONE, EV_UNKNOWN, 7'd0, HOST_A, 1'b0}},
		'{'{HOST_A, 32'h0, OPEN_FIRST_RST}, 1'b1,
			'{ACT_NONE, EV_ADD_OPEN, 7'd0, HOST_A, 1'b0}},
		'{'{HOST_A, 32'h0, OPEN_SECOND_RST}, 1'b0, '0},
		'{'{HOST_A, 32'h0, OPEN_THIRD_RST}, 1'b1,
			'{ACT_GRANT, EV_OPENED, 7'd0, HOST_A, 1'b1}},
		'{'{HOST_A, 32'h0, OPEN_FIRST_RST}, 1'b1,
			'{ACT_NONE, EV_ALREADY_OPEN, 7'd0, HOST_A, 1'b1}},
		'{'{HOST_A, 32'h0, CLOSE_FIRST_RST}, 1'b0, '0},
		'{'{HOST_A, 32'h0, CLOSE_THIRD_RST}, 1'b0, '0},
		'{'{HOST_A, 32'h0, CLOSE_SECOND_RST}, 1'b0, '0},
		'{'{HOST_A, 32'h0, CLOSE_THIRD_RST}, 1'b1,
			'{ACT_REVOKE, EV_CLOSED, 7'd0, HOST_A, 1'b0}},
		'{'{HOST_A, 32'h0, CLOSE_SECOND_RST}, 1'b1,
			'{ACT_NONE, EV_ALREADY_CLOSED, 7'd0, HOST_A, 1'b0}},
		'{'{HOST_B, 32'h0, CLOSE_FIRST_RST}, 1'b1,
			'{ACT_NONE, EV_ADD_CLOSE, 7'd1, HOST_B, 1'b0}},
		'{'{HOST_B, 32'h0, OPEN_FIRST_RST}, 1'b0, '0},
		'{'{HOST_B, 32'h0, OPEN_SECOND_RST}, 1'b0, '0},
		'{'{HOST_B, 32'h0, OPEN_THIRD_RST}, 1'b0, '0},
		'{'{HOST_B, 32'h0, CLOSE_SECOND_RST}, 1'b0, '0},
		'{'{HOST_B, 32'h0, CLOSE_THIRD_RST}, 1'b0, '0},
		'{'{HOST_C, 32'h0, OPEN_FIRST_RST}, 1'b1,
			'{ACT_NONE, EV_ADD_OPEN, 7'd2, HOST_C, 1'b0}},
		'{'{HOST_C, 32'h0, 16'hFFFF}, 1'b1,
			'{ACT_NONE, EV_WRONG_RESET, 7'd2, HOST_C, 1'b0}},
		'{'{HOST_C, 32'h0, OPEN_SECOND_RST}, 1'b0, '0},
		'{'{HOST_C, 32'h0, 16'h0000}, 1'b0, '0},
		'{'{HOST_B, HOST_B, OPEN_FIRST_RST}, 1'b1,
			'{ACT_NONE, EV_OTHER_HOST, 7'd0, HOST_B, 1'b0}},
		'{'{HOST_C, 32'h0, OPEN_THIRD_RST}, 1'b0, '0}
	};

	port_knock_tracker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.pkt       (pkt),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int idle_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 150);
	endfunction

	// Works out the result word for one packet and updates the client table.
	function automatic res_t track_knock(input pkt_t p);
		res_t        r;
		int          i;
		int          slot;
		bit          hit;
		bit          in_open;
		bit          in_close;
		logic [15:0] port;
		port = p.dest_port;
		r = '{ACT_NONE, EV_OTHER_HOST, 7'd0, p.source_addr, 1'b0};
		if (p.dest_addr != knock_cfg.local_addr)
			return r;
		hit = 1'b0;
		slot = 0;
		for (i = 0; i < known_count; i++) begin
			if (!hit && tab_addr[i] == p.source_addr) begin
				hit = 1'b1;
				slot = i;
			end
		end
		if (!hit) begin
			if (port != knock_cfg.open_first && port != knock_cfg.close_first) begin
				r.event_res = EV_UNKNOWN;
				return r;
			end
			if (known_count >= MAX_CLIENTS) begin
				r.event_res = EV_TABLE_FULL;
				return r;
			end
			slot = known_count;
			known_count++;
			tab_addr[slot] = p.source_addr;
			tab_status[slot] = 1'b0;
			tab_open[slot] = 2'd0;
			tab_close[slot] = 2'd0;
			r.client_slot = 7'(slot);
			// The open port wins when both first ports are equal.
			if (port == knock_cfg.open_first) begin
				tab_open[slot] = 2'd1;
				r.event_res = EV_ADD_OPEN;
			end else begin
				tab_close[slot] = 2'd1;
				r.event_res = EV_ADD_CLOSE;
			end
			return r;
		end
		r.client_slot = 7'(slot);
		in_open = port == knock_cfg.open_first || port == knock_cfg.open_second ||
			port == knock_cfg.open_third;
		in_close = port == knock_cfg.close_first || port == knock_cfg.close_second ||
			port == knock_cfg.close_third;
		if (in_open) begin
			if (tab_status[slot]) begin
				r.event_res = EV_ALREADY_OPEN;
			end else if (port == knock_cfg.open_first) begin
				tab_open[slot] = 2'd1;
				r.event_res = EV_OPEN_STEP;
			end else if (tab_open[slot] == 2'd1 && port == knock_cfg.open_second) begin
				tab_open[slot] = 2'd2;
				r.event_res = EV_OPEN_STEP;
			end else if (tab_open[slot] == 2'd2 && port == knock_cfg.open_third) begin
				tab_status[slot] = 1'b1;
				tab_open[slot] = 2'd0;
				r.action = ACT_GRANT;
				r.event_res = EV_OPENED;
			end else begin
				r.event_res = EV_NO_CHANGE;
			end
		end else if (in_close) begin
			if (!tab_status[slot]) begin
				r.event_res = EV_ALREADY_CLOSED;
			end else if (port == knock_cfg.close_first) begin
				tab_close[slot] = 2'd1;
				r.event_res = EV_CLOSE_STEP;
			end else if (tab_close[slot] == 2'd1 && port == knock_cfg.close_second) begin
				tab_close[slot] = 2'd2;
				r.event_res = EV_CLOSE_STEP;
			end else if (tab_close[slot] == 2'd2 && port == knock_cfg.close_third) begin
				tab_status[slot] = 1'b0;
				tab_close[slot] = 2'd0;
				r.action = ACT_REVOKE;
				r.event_res = EV_CLOSED;
			end else begin
				r.event_res = EV_NO_CHANGE;
			end
		end else begin
			tab_open[slot] = 2'd0;
			tab_close[slot] = 2'd0;
			r.event_res = EV_WRONG_RESET;
		end
		r.access_open = tab_status[slot];
		return r;
	endfunction

	function automatic logic [15:0] stray_port();
		if ($urandom_range(0, 1) != 0)
			return 16'($urandom);
		case ($urandom_range(0, 5))
			0: return knock_cfg.open_first;
			1: return knock_cfg.open_second;
			2: return knock_cfg.open_third;
			3: return knock_cfg.close_first;
			4: return knock_cfg.close_second;
			default: return knock_cfg.close_third;
		endcase
	endfunction

	// Leaves pkt_valid high after the word is taken so that the next one can follow at once.
	task automatic send_pkt(input pkt_t p, input bit typed, input res_t typed_res);
		int   gap;
		res_t predicted;
		gap = idle_len();
		if (gap > 0) begin
			pkt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pkt <= p;
		pkt_valid <= 1'b1;
		do @(posedge clk); while (pkt_stall);
		total_pkts++;
		if (p.dest_addr == knock_cfg.local_addr)
			host_pkts++;
		predicted = track_knock(p);
		pending.push_back(typed ? typed_res : predicted);
	endtask

	task automatic knock(input logic [31:0] src, input logic [31:0] dst, input logic [15:0] port);
		send_pkt(pkt_t'{src, dst, port}, 1'b0, res_t'('0));
	endtask

	task automatic settle();
		pkt_valid <= 1'b0;
		do @(posedge clk); while (pending.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_LOCAL_ADDR:   knock_cfg.local_addr = val;
			REG_OPEN_FIRST:   knock_cfg.open_first = val[15:0];
			REG_OPEN_SECOND:  knock_cfg.open_second = val[15:0];
			REG_OPEN_THIRD:   knock_cfg.open_third = val[15:0];
			REG_CLOSE_FIRST:  knock_cfg.close_first = val[15:0];
			REG_CLOSE_SECOND: knock_cfg.close_second = val[15:0];
			REG_CLOSE_THIRD:  knock_cfg.close_third = val[15:0];
			default: ;
		endcase
	endtask

	// Port registers get junk in the upper half, which must be dropped.
	task automatic program_regs(input cfg_t c);
		write_reg(REG_LOCAL_ADDR, c.local_addr);
		write_reg(REG_OPEN_FIRST, {16'($urandom), c.open_first});
		write_reg(REG_OPEN_SECOND, {16'($urandom), c.open_second});
		write_reg(REG_OPEN_THIRD, {16'($urandom), c.open_third});
		write_reg(REG_CLOSE_FIRST, {16'($urandom), c.close_first});
		write_reg(REG_CLOSE_SECOND, {16'($urandom), c.close_second});
		write_reg(REG_CLOSE_THIRD, {16'($urandom), c.close_third});
		write_reg(REG_SPARE, $urandom);
		cfg_valid <= 1'b0;
		settings_done++;
	endtask

	// Mostly whole open or close sequences from known clients, with some broken
	// sequences, stray ports, other hosts and new sources mixed in.
	task automatic knock_bursts(input int budget);
		int          start;
		int          sel;
		int          n;
		int          k;
		logic [31:0] who;
		logic [31:0] dst;
		logic [15:0] seq [3];
		start = host_pkts;
		while (host_pkts - start < budget) begin
			calm = ($urandom_range(0, 9) == 0);
			who = client_pool[$urandom_range(0, client_pool.size() - 1)];
			dst = knock_cfg.local_addr;
			n = 1;
			sel = $urandom_range(0, 99);
			if (sel < 35) begin
				seq[0] = knock_cfg.open_first;
				seq[1] = knock_cfg.open_second;
				seq[2] = knock_cfg.open_third;
				n = 3;
			end else if (sel < 65) begin
				seq[0] = knock_cfg.close_first;
				seq[1] = knock_cfg.close_second;
				seq[2] = knock_cfg.close_third;
				n = 3;
			end else if (sel < 80) begin
				seq[0] = stray_port();
			end else if (sel < 90) begin
				seq[0] = 16'($urandom);
			end else if (sel < 95) begin
				dst = $urandom;
				who = $urandom;
				seq[0] = stray_port();
			end else begin
				who = $urandom;
				seq[0] = ($urandom_range(0, 1) != 0) ? knock_cfg.open_first : knock_cfg.close_first;
				if ($urandom_range(0, 3) == 0)
					seq[0] = 16'($urandom);
			end
			if (n == 3 && $urandom_range(0, 9) == 0)
				seq[$urandom_range(0, 2)] = stray_port();
			for (k = 0; k < n; k++)
				knock(who, dst, seq[k]);
		end
		calm = 1'b0;
	endtask

	initial begin : res_stall_gen
		int hold;
		int free;
		hold = 0;
		free = 0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				res_stall <= 1'b1;
				hold--;
			end else begin
				res_stall <= 1'b0;
				if (free > 0) begin
					free--;
				end else begin
					hold = idle_len();
					free = $urandom_range(1, 8);
				end
			end
		end
	end

	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending.size() == 0) begin
				$error("result word with nothing pending: %p", res);
				mismatches++;
			end else begin
				want = pending.pop_front();
				seen_event[want.event_res]++;
				if (res.action !== want.action) begin
					$error("action: expected %0d, got %0d", want.action, res.action);
					mismatches++;
				end
				if (res.event_res !== want.event_res) begin
					$error("event_res: expected %0d, got %0d", want.event_res, res.event_res);
					mismatches++;
				end
				if (res.client_slot !== want.client_slot) begin
					$error("client_slot: expected %0d, got %0d", want.client_slot,
						res.client_slot);
					mismatches++;
				end
				if (res.client_addr !== want.client_addr) begin
					$error("client_addr: expected %h, got %h", want.client_addr,
						res.client_addr);
					mismatches++;
				end
				if (res.access_open !== want.access_open) begin
					$error("access_open: expected %0d, got %0d", want.access_open,
						res.access_open);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((pkt_valid && !pkt_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("no handshake for %0d cycles, %0d results pending", quiet_cycles,
				pending.size());
			$display("port_knock_tracker verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		int          n;
		int          ph;
		cfg_t        c;
		logic [31:0] fresh;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (n = 0; n < $size(script); n++)
			send_pkt(script[n].p, script[n].typed, script[n].want);

		for (ph = 0; ph < 5; ph++) begin
			settle();
			c.local_addr = $urandom;
			c.open_first = 16'($urandom);
			c.open_second = 16'($urandom);
			c.open_third = 16'($urandom);
			c.close_first = 16'($urandom);
			c.close_second = 16'($urandom);
			c.close_third = 16'($urandom);
			case (ph)
				1: begin
					// All-ones host; the first close port is also an open port.
					c.local_addr = '1;
					c.open_first = '0;
					c.open_second = '1;
					c.open_third = 16'h8000;
					c.close_first = '1;
					c.close_second = 16'h7FFF;
					c.close_third = '0;
				end
				2: c.close_first = c.open_first;
				3: begin
					// Ports drawn from four values, so the sets collide often.
					c.local_addr = '0;
					c.open_first = 16'($urandom_range(10, 13));
					c.open_second = 16'($urandom_range(10, 13));
					c.open_third = 16'($urandom_range(10, 13));
					c.close_first = 16'($urandom_range(10, 13));
					c.close_second = 16'($urandom_range(10, 13));
					c.close_third = 16'($urandom_range(10, 13));
				end
				default: ;
			endcase
			program_regs(c);
			repeat (4) client_pool.push_back($urandom);
			knock_bursts(260);
		end

		// Fill the table to the last slot, then knock from new sources against a full table.
		settle();
		c = '{32'h0, OPEN_FIRST_RST, OPEN_SECOND_RST, OPEN_THIRD_RST,
			CLOSE_FIRST_RST, CLOSE_SECOND_RST, CLOSE_THIRD_RST};
		c.local_addr = $urandom;
		program_regs(c);
		fresh = $urandom;
		while (known_count < MAX_CLIENTS) begin
			fresh = $urandom;
			knock(fresh, knock_cfg.local_addr,
				($urandom_range(0, 1) != 0) ? knock_cfg.open_first : knock_cfg.close_first);
		end
		client_pool.push_back(fresh);
		knock($urandom, knock_cfg.local_addr, knock_cfg.open_first);
		knock($urandom, knock_cfg.local_addr, knock_cfg.close_first);
		knock($urandom, knock_cfg.local_addr, 16'h5A5A);
		knock_bursts(160);

		settle();
		repeat (300) @(posedge clk);
		$display("%0d packets sent, %0d to this host, across %0d register settings; %0d clients.",
			total_pkts, host_pkts, settings_done, known_count);
		$display("grants %0d, revokes %0d, table-full refusals %0d, other-host drops %0d.",
			seen_event[EV_OPENED], seen_event[EV_CLOSED], seen_event[EV_TABLE_FULL],
			seen_event[EV_OTHER_HOST]);
		if (mismatches == 0)
			$display("port_knock_tracker verification clean");
		else
			$display("port_knock_tracker verification failed");
		$finish;
	end

endmodule

@@ files.f @@
rtl/pkt_pkg.sv
rtl/pkt_table.sv
rtl/pkt_fsm.sv
rtl/port_knock_tracker.sv
bench/testbench.sv
